@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Simulation builds get the checks;
// synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SFM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SFM_ASSERT_IMP(name, clk, rst, ante, cons)
`define SFM_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/sfm_pkg.sv @@
package sfm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned PATTERN_MAX_DEFAULT   = 16;
  localparam int unsigned POSITION_BITS_DEFAULT = 16;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned TEXT_BYTE_W      = 8;
  localparam int unsigned POSITION_W       = 16;
  localparam int unsigned PATTERN_LENGTH_W = 5;
  localparam int unsigned CFG_DATA_W       = 64;
  localparam int unsigned CFG_INDEX_W      = 2;

  // Number of pattern bytes held by the two pattern registers.
  localparam int unsigned PATTERN_REG_BYTES = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

endpackage

@@ rtl/sfm_text_if.sv @@
interface sfm_text_if;
  import sfm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TEXT_BYTE_W-1:0] text_byte;
  logic                   has_byte;
  logic                   last;

  modport source (output valid, output text_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input text_byte, input has_byte, input last,
                output ready);
endinterface

@@ rtl/sfm_result_if.sv @@
interface sfm_result_if;
  import sfm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [POSITION_W-1:0] position;
  logic                  overflow;

  modport source (output valid, output found, output position, output overflow,
                  input ready);
  modport sink (input valid, input found, input position, input overflow,
                output ready);
endinterface

@@ rtl/substring_first_match_top.sv @@
// Channel   Role   Handshake     Payload
// text      sink   valid/ready   text_byte[7:0], has_byte, last
// result    source valid/ready   found, position[15:0], overflow
// config    write  write_enable  reg_index[1:0], write_data[63:0]
//
// One text item is taken per cycle unless a last item waits on a held result;
// each passes the input register, its compare against the window happening as
// it leaves. A result is registered as its last item leaves the input register.
// Reset (rst, synchronous, active high) clears the pattern registers and the
// stream state. A held result stalls only a last item, and the input behind it.
`include "assert_macros.svh"

module substring_first_match_top #(
  parameter int unsigned PATTERN_MAX   = sfm_pkg::PATTERN_MAX_DEFAULT,
  parameter int unsigned POSITION_BITS = sfm_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [sfm_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]  write_data,
  sfm_text_if.sink                        text,
  sfm_result_if.source                    result
);
  import sfm_pkg::*;

  // Width of an index into the pattern byte array, and that array's size
  // rounded up to a power of two so every index value is in range.
  localparam int unsigned IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned PAT_SLOTS = 1 << IDX_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0]       pattern_low;
  logic [CFG_DATA_W-1:0]       pattern_high;
  logic [PATTERN_LENGTH_W-1:0] pattern_length;

  // Input register.
  logic                   in_valid;
  logic [TEXT_BYTE_W-1:0] in_byte;
  logic                   in_has;
  logic                   in_last;

  // Stream state. Entry 0 of the window is the newest byte.
  logic [TEXT_BYTE_W-1:0]   window [PATTERN_MAX];
  logic [TEXT_BYTE_W-1:0]   window_next [PATTERN_MAX];
  logic [POSITION_BITS-1:0] text_count, text_count_next;
  logic                     match_seen, match_seen_next;
  logic [POSITION_BITS-1:0] match_start, match_start_next;
  logic                     too_long, too_long_next;

  // Result register.
  logic                  res_valid;
  logic                  res_found;
  logic [POSITION_W-1:0] res_position;
  logic                  res_overflow;

  // Combinational helpers.
  logic [TEXT_BYTE_W-1:0]          pat_byte [PAT_SLOTS];
  logic [TEXT_BYTE_W-1:0]          window_shift [PATTERN_MAX];
  logic [POSITION_BITS-1:0]        count_inc;
  logic                            count_full;
  logic                            len_ok;
  logic                            hit;
  logic                            out_space;
  logic                            proc_fire;
  logic                            res_load;
  logic                            found_now;
  logic                            overflow_now;
  logic [POSITION_BITS+POSITION_W-1:0] start_ext;

  // The pattern registers provide sixteen bytes; any further slots read zero.
  always_comb begin
    for (int k = 0; k < PAT_SLOTS; k++) begin
      if (k < 8) begin
        pat_byte[k] = pattern_low[8*k +: 8];
      end else if (k < PATTERN_REG_BYTES) begin
        pat_byte[k] = pattern_high[8*(k-8) +: 8];
      end else begin
        pat_byte[k] = '0;
      end
    end
  end

  // Window as it stands after the byte in the input register moves in.
  always_comb begin
    window_shift[0] = in_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_shift[j] = window[j-1];
    end
  end

  assign count_full = &text_count;
  assign count_inc  = text_count + POSITION_BITS'(1);
  assign len_ok     = (pattern_length != '0) && (32'(pattern_length) <= PATTERN_MAX);

  // Parallel compare: window entry j holds the byte that pattern byte
  // length-1-j must equal. Entries at or beyond the length do not take part.
  always_comb begin
    hit = len_ok && (32'(count_inc) >= 32'(pattern_length));
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (32'(j) < 32'(pattern_length)) begin
        if (window_shift[j] !=
            pat_byte[IDX_W'(32'(pattern_length) - 32'(j) - 32'd1)]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // An item without last never waits for the result register; one with last
  // needs room there for its result.
  assign out_space  = !res_valid || result.ready;
  assign proc_fire  = in_valid && (!in_last || out_space);
  assign res_load   = proc_fire && in_last;
  assign text.ready = !in_valid || proc_fire;

  always_comb begin
    window_next      = window;
    text_count_next  = text_count;
    match_seen_next  = match_seen;
    match_start_next = match_start;
    too_long_next    = too_long;

    if (proc_fire && in_has) begin
      if (count_full) begin
        // The text has reached its maximum length; the byte is dropped.
        too_long_next = 1'b1;
      end else begin
        window_next     = window_shift;
        text_count_next = count_inc;
        if (!match_seen && hit) begin
          match_seen_next  = 1'b1;
          match_start_next = count_inc - POSITION_BITS'(pattern_length);
        end
      end
    end

    // An empty pattern always matches at the start of the text. When nothing
    // matched, match_start is still zero.
    found_now    = (pattern_length == '0) || match_seen_next;
    start_ext    = {{POSITION_W{1'b0}}, match_start_next};
    // The overflow flag of the finishing text, taken before it is cleared.
    overflow_now = too_long_next;

    if (res_load) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window_next[j] = '0;
      end
      text_count_next  = '0;
      match_seen_next  = 1'b0;
      match_start_next = '0;
      too_long_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_PATTERN_LOW:    pattern_low    <= write_data;
        REG_PATTERN_HIGH:   pattern_high   <= write_data;
        REG_PATTERN_LENGTH: pattern_length <= write_data[PATTERN_LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_byte <= text.text_byte;
      in_has  <= text.has_byte;
      in_last <= text.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window[j] <= '0;
      end
      text_count  <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
      too_long    <= 1'b0;
    end else begin
      window      <= window_next;
      text_count  <= text_count_next;
      match_seen  <= match_seen_next;
      match_start <= match_start_next;
      too_long    <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_found    <= found_now;
      res_position <= start_ext[POSITION_W-1:0];
      res_overflow <= overflow_now;
    end
  end

  assign result.valid    = res_valid;
  assign result.found    = res_found;
  assign result.position = res_position;
  assign result.overflow = res_overflow;

  // Finishing a text leaves the stream state clean for the next one.
  `SFM_ASSERT_NXT(a_clear_after_last, clk, rst, res_load, (text_count == '0) && !match_seen && !too_long)
  // A recorded match starts before the end of the bytes counted so far.
  `SFM_ASSERT_IMP(a_start_in_text, clk, rst, match_seen, match_start < text_count)
  // Bytes are only dropped once the count has saturated.
  `SFM_ASSERT_IMP(a_overflow_saturated, clk, rst, too_long, count_full)
  // A waiting item in the input register stays there until it is processed.
  `SFM_ASSERT_NXT(a_input_held, clk, rst, in_valid && !proc_fire, in_valid)

endmodule
